// ----- design/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// sme_pkg
// Shared constants of the stack machine execute unit: sizes, opcodes, status.
// ----------------------------------------------------------------------------
package sme_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF      = 1024;
    localparam int LOCALS_PER_FRAME_DEF = 256;
    localparam int FRAME_DEPTH_DEF      = 16;
    localparam int CODE_ADDR_BITS_DEF   = 16;

    // opcodes
    localparam logic [7:0] OP_NOP        = 8'h00;
    localparam logic [7:0] OP_PUSH_BYTE  = 8'h10;
    localparam logic [7:0] OP_PUSH_CONST = 8'h13;
    localparam logic [7:0] OP_LOAD_VAR   = 8'h15;
    localparam logic [7:0] OP_STORE_VAR  = 8'h36;
    localparam logic [7:0] OP_POP        = 8'h57;
    localparam logic [7:0] OP_DUP        = 8'h59;
    localparam logic [7:0] OP_SWAP       = 8'h5f;
    localparam logic [7:0] OP_IADD       = 8'h60;
    localparam logic [7:0] OP_ISUB       = 8'h64;
    localparam logic [7:0] OP_IAND       = 8'h7e;
    localparam logic [7:0] OP_IINC       = 8'h84;
    localparam logic [7:0] OP_IFEQ       = 8'h99;
    localparam logic [7:0] OP_IFLT       = 8'h9b;
    localparam logic [7:0] OP_CMP_EQ_BR  = 8'h9f;
    localparam logic [7:0] OP_GOTO       = 8'ha7;
    localparam logic [7:0] OP_IRET       = 8'hac;
    localparam logic [7:0] OP_IOR        = 8'hb0;
    localparam logic [7:0] OP_INVOKE     = 8'hb6;
    localparam logic [7:0] OP_WIDE       = 8'hc4;
    localparam logic [7:0] OP_IN         = 8'hfc;
    localparam logic [7:0] OP_OUT        = 8'hfd;
    localparam logic [7:0] OP_ERR        = 8'hfe;
    localparam logic [7:0] OP_HALT       = 8'hff;

    // status codes
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd4;

    // input byte that means no data
    localparam logic [7:0] IN_NONE = 8'hff;

endpackage

// ----- design/sme_operand_stack.sv -----
// ----------------------------------------------------------------------------
// sme_operand_stack
// Operand stack memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sme_operand_stack #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [31:0]   rd_data_a,
    output logic [31:0]   rd_data_b
);

    logic [31:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- design/stack_machine_execute_unit.sv -----
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one decoded IJVM instruction per transaction against an operand
// stack, per-frame local variables and a frame stack held in memories.
// ----------------------------------------------------------------------------
//  channel  direction  ports        payload
//  s_       in         s_valid/rdy  mode, instr_addr, byte_arg, inc_arg,
//                                   short_arg, pool_word, method_args, in_byte
//  m_       out        m_valid/rdy  next_pc, out_valid, out_byte, status
//
//  one instruction at a time: accept, memory read, execute, result
//  SWAP does its second stack write in a state of its own (single write port)
//  INVOKEVIRTUAL with arguments copies them to locals in S_COPY, one copy per cycle
//  reset (aresetn low, synchronous) empties stack and frames, no memory sweep
//  a stalled result register holds the unit in S_DONE and blocks the next instruction
module stack_machine_execute_unit
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH      = STACK_DEPTH_DEF,
    parameter int LOCALS_PER_FRAME = LOCALS_PER_FRAME_DEF,
    parameter int FRAME_DEPTH      = FRAME_DEPTH_DEF,
    parameter int CODE_ADDR_BITS   = CODE_ADDR_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_mode,
    input  logic [15:0]         s_instr_addr,
    input  logic [7:0]          s_byte_arg,
    input  logic signed [7:0]   s_inc_arg,
    input  logic signed [15:0]  s_short_arg,
    input  logic signed [31:0]  s_pool_word,
    input  logic [7:0]          s_method_args,
    input  logic [7:0]          s_in_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_next_pc,
    output logic                m_out_valid,
    output logic [7:0]          m_out_byte,
    output logic [STATUS_W-1:0] m_status
);

    localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TW   = $clog2(STACK_DEPTH + 1);
    localparam int LIW  = $clog2(LOCALS_PER_FRAME);
    localparam int FW   = $clog2(FRAME_DEPTH);
    localparam int LDEP = FRAME_DEPTH * LOCALS_PER_FRAME;
    localparam int LAW  = $clog2(LDEP);
    localparam int CNTW = 9;
    localparam int DW   = (TW > CNTW) ? TW : CNTW;
    localparam logic [15:0] PC_MASK = (CODE_ADDR_BITS >= 16) ? 16'hffff :
        16'((32'd1 << CODE_ADDR_BITS) - 32'd1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_SWAP = 3'd3;
    localparam logic [2:0] S_COPY = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [TW-1:0]       top_reg, top_next;
    logic [TW-1:0]       base_reg, base_next;
    logic [FW-1:0]       level_reg, level_next;
    logic                fin_reg, fin_next;

    // captured instruction
    logic [7:0]          mode_reg;
    logic [15:0]         addr_reg;
    logic [7:0]          barg_reg;
    logic signed [7:0]   inc_reg;
    logic signed [15:0]  off_reg;
    logic [31:0]         pool_reg;
    logic [7:0]          nargs_reg;
    logic [7:0]          inb_reg;

    // result holding and output registers
    logic [15:0]         res_pc_reg, res_pc_next;
    logic                res_ov_reg, res_ov_next;
    logic [7:0]          res_ob_reg, res_ob_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                m_valid_reg;
    logic [15:0]         m_pc_reg;
    logic                m_ov_reg;
    logic [7:0]          m_ob_reg;
    logic [STATUS_W-1:0] m_st_reg;

    // copy loop
    logic [CNTW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [CNTW-1:0]     wr_cnt_reg, wr_cnt_next;
    logic                pend_reg, pend_next;
    logic [31:0]         swap_reg;

    // memories
    logic [31:0]         loc_mem [LDEP];
    logic [15:0]         frp_mem [FRAME_DEPTH];
    logic [TW-1:0]       frb_mem [FRAME_DEPTH];
    logic [31:0]         loc_rd;
    logic [15:0]         frp_rd;
    logic [TW-1:0]       frb_rd;

    logic                stk_we;
    logic [SW-1:0]       stk_wa;
    logic [31:0]         stk_wd;
    logic [SW-1:0]       stk_ra_a, stk_ra_b;
    logic [31:0]         stk_rd_a, stk_rd_b;
    logic                loc_we;
    logic [LAW-1:0]      loc_wa, loc_ra;
    logic [31:0]         loc_wd;
    logic                fr_we;

    logic                accept, out_free;
    logic [LIW-1:0]      mod_tab [256];
    logic [LIW-1:0]      lidx;
    logic [LAW-1:0]      slot;
    logic [TW-1:0]       depth;
    logic                full;
    logic [15:0]         pc_br;

    // local index modulo the window size
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_tab[g] = LIW'(g % LOCALS_PER_FRAME);
    end

    assign lidx   = mod_tab[barg_reg];
    assign slot   = LAW'(32'(level_reg) * LOCALS_PER_FRAME + 32'(lidx));
    assign depth  = top_reg - base_reg;
    assign full   = (top_reg >= TW'(STACK_DEPTH));
    assign pc_br  = addr_reg + off_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) || ((state_reg == S_DONE) && out_free);
    assign accept   = s_valid && s_ready;

    // operand stack
    assign stk_ra_a = (state_reg == S_COPY) ? SW'(base_reg + TW'(rd_cnt_reg))
                                            : SW'(top_reg - TW'(1));
    assign stk_ra_b = SW'(top_reg - TW'(2));

    sme_operand_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (SW)
    ) u_stack (
        .aclk      (aclk),
        .wr_en     (stk_we),
        .wr_addr   (stk_wa),
        .wr_data   (stk_wd),
        .rd_addr_a (stk_ra_a),
        .rd_addr_b (stk_ra_b),
        .rd_data_a (stk_rd_a),
        .rd_data_b (stk_rd_b)
    );

    // local variable memory
    assign loc_ra = slot;
    always_ff @(posedge aclk) begin
        if (loc_we) begin
            loc_mem[loc_wa] <= loc_wd;
        end
        loc_rd <= loc_mem[loc_ra];
    end

    // frame stack memory, read at the caller's entry
    always_ff @(posedge aclk) begin
        if (fr_we) begin
            frp_mem[level_reg] <= (addr_reg + 16'd3) & PC_MASK;
            frb_mem[level_reg] <= base_reg;
        end
        frp_rd <= frp_mem[FW'(level_reg - FW'(1))];
        frb_rd <= frb_mem[FW'(level_reg - FW'(1))];
    end

    // execute and sequencing
    always_comb begin
        logic [STATUS_W-1:0] st;
        logic [15:0]         pc;
        logic [31:0]         a, b;
        st          = ST_RUN;
        pc          = addr_reg;
        a           = stk_rd_a;
        b           = stk_rd_b;
        state_next  = state_reg;
        top_next    = top_reg;
        base_next   = base_reg;
        level_next  = level_reg;
        fin_next    = fin_reg;
        res_pc_next = res_pc_reg;
        res_ov_next = res_ov_reg;
        res_ob_next = res_ob_reg;
        res_st_next = res_st_reg;
        rd_cnt_next = rd_cnt_reg;
        wr_cnt_next = wr_cnt_reg;
        pend_next   = 1'b0;
        stk_we      = 1'b0;
        stk_wa      = SW'(top_reg);
        stk_wd      = a;
        loc_we      = 1'b0;
        loc_wa      = slot;
        loc_wd      = a;
        fr_we       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                res_ov_next = 1'b0;
                res_ob_next = 8'd0;
                state_next  = S_DONE;
                if (fin_reg) begin
                    st = ST_HALT;
                end else begin
                    unique case (mode_reg)
                        OP_PUSH_BYTE, OP_PUSH_CONST, OP_LOAD_VAR, OP_IN: begin
                            if (full) begin
                                st = ST_OVER;
                            end else begin
                                stk_we   = 1'b1;
                                top_next = top_reg + TW'(1);
                                if (mode_reg == OP_PUSH_BYTE) begin
                                    stk_wd = {{24{barg_reg[7]}}, barg_reg};
                                    pc     = addr_reg + 16'd2;
                                end else if (mode_reg == OP_PUSH_CONST) begin
                                    stk_wd = pool_reg;
                                    pc     = addr_reg + 16'd3;
                                end else if (mode_reg == OP_LOAD_VAR) begin
                                    stk_wd = loc_rd;
                                    pc     = addr_reg + 16'd2;
                                end else begin
                                    stk_wd = (inb_reg == IN_NONE) ? 32'd0 : {24'd0, inb_reg};
                                    pc     = addr_reg + 16'd1;
                                end
                            end
                        end
                        OP_DUP: begin
                            if (depth == '0) begin
                                st = ST_UNDER;
                            end else if (full) begin
                                st = ST_OVER;
                            end else begin
                                stk_we   = 1'b1;
                                top_next = top_reg + TW'(1);
                                pc       = addr_reg + 16'd1;
                            end
                        end
                        OP_ERR: st = ST_ERR;
                        OP_HALT: st = ST_HALT;
                        OP_GOTO: pc = pc_br;
                        OP_IADD, OP_ISUB, OP_IAND, OP_IOR, OP_SWAP: begin
                            if (depth < TW'(2)) begin
                                st = ST_UNDER;
                            end else begin
                                stk_we = 1'b1;
                                stk_wa = SW'(top_reg - TW'(2));
                                pc     = addr_reg + 16'd1;
                                unique case (mode_reg)
                                    OP_IADD: stk_wd = b + a;
                                    OP_ISUB: stk_wd = b - a;
                                    OP_IAND: stk_wd = b & a;
                                    OP_IOR:  stk_wd = b | a;
                                    default: stk_wd = a;
                                endcase
                                if (mode_reg == OP_SWAP) begin
                                    state_next = S_SWAP;
                                end else begin
                                    top_next = top_reg - TW'(1);
                                end
                            end
                        end
                        OP_IFEQ, OP_IFLT: begin
                            if (depth == '0) begin
                                st = ST_UNDER;
                            end else begin
                                top_next = top_reg - TW'(1);
                                if ((mode_reg == OP_IFEQ && a == 32'd0) ||
                                    (mode_reg == OP_IFLT && a[31])) begin
                                    pc = pc_br;
                                end else begin
                                    pc = addr_reg + 16'd3;
                                end
                            end
                        end
                        OP_CMP_EQ_BR: begin
                            if (depth < TW'(2)) begin
                                st = ST_UNDER;
                            end else begin
                                top_next = top_reg - TW'(2);
                                pc       = (a == b) ? pc_br : addr_reg + 16'd3;
                            end
                        end
                        OP_IINC: begin
                            loc_we = 1'b1;
                            loc_wd = loc_rd + 32'(inc_reg);
                            pc     = addr_reg + 16'd3;
                        end
                        OP_STORE_VAR: begin
                            if (depth == '0) begin
                                st = ST_UNDER;
                            end else begin
                                loc_we   = 1'b1;
                                top_next = top_reg - TW'(1);
                                pc       = addr_reg + 16'd2;
                            end
                        end
                        OP_INVOKE: begin
                            if (DW'(depth) < DW'(nargs_reg)) begin
                                st = ST_UNDER;
                            end else if (level_reg == FW'(FRAME_DEPTH - 1) ||
                                         32'(nargs_reg) > LOCALS_PER_FRAME) begin
                                st = ST_OVER;
                            end else begin
                                fr_we       = 1'b1;
                                top_next    = top_reg - TW'(nargs_reg);
                                base_next   = top_reg - TW'(nargs_reg);
                                level_next  = level_reg + FW'(1);
                                pc          = pool_reg[15:0] + 16'd4;
                                rd_cnt_next = '0;
                                wr_cnt_next = '0;
                                if (nargs_reg != 8'd0) begin
                                    state_next = S_COPY;
                                end
                            end
                        end
                        OP_IRET: begin
                            if (depth == '0 || level_reg == '0) begin
                                st = ST_UNDER;
                            end else begin
                                // result lands where the callee's frame began
                                stk_we     = 1'b1;
                                stk_wa     = SW'(base_reg);
                                top_next   = base_reg + TW'(1);
                                base_next  = frb_rd;
                                level_next = level_reg - FW'(1);
                                pc         = frp_rd;
                            end
                        end
                        OP_OUT: begin
                            if (depth == '0) begin
                                st = ST_UNDER;
                            end else begin
                                top_next    = top_reg - TW'(1);
                                res_ov_next = 1'b1;
                                res_ob_next = a[7:0];
                                pc          = addr_reg + 16'd1;
                            end
                        end
                        OP_POP: begin
                            if (depth == '0) begin
                                st = ST_UNDER;
                            end else begin
                                top_next = top_reg - TW'(1);
                                pc       = addr_reg + 16'd1;
                            end
                        end
                        OP_NOP, OP_WIDE: pc = addr_reg + 16'd1;
                        default: st = ST_ERR;
                    endcase
                    // halt, error, underflow or overflow: nothing changes but the finished flag
                    if (st != ST_RUN) begin
                        fin_next   = 1'b1;
                        pc         = addr_reg;
                        stk_we     = 1'b0;
                        loc_we     = 1'b0;
                        fr_we      = 1'b0;
                        top_next   = top_reg;
                        base_next  = base_reg;
                        level_next = level_reg;
                        state_next = S_DONE;
                    end
                end
                res_pc_next = pc & PC_MASK;
                res_st_next = st;
            end
            S_SWAP: begin
                stk_we     = 1'b1;
                stk_wa     = SW'(top_reg - TW'(1));
                stk_wd     = swap_reg;
                state_next = S_DONE;
            end
            S_COPY: begin
                // read argument k, write it to local k in the next cycle
                if (rd_cnt_reg < CNTW'(nargs_reg)) begin
                    rd_cnt_next = rd_cnt_reg + CNTW'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg) begin
                    loc_we      = 1'b1;
                    loc_wa      = LAW'(32'(level_reg) * LOCALS_PER_FRAME + 32'(wr_cnt_reg));
                    loc_wd      = stk_rd_a;
                    wr_cnt_next = wr_cnt_reg + CNTW'(1);
                    if (wr_cnt_next == CNTW'(nargs_reg)) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = accept ? S_READ : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            top_reg     <= '0;
            base_reg    <= '0;
            level_reg   <= '0;
            fin_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            base_reg  <= base_next;
            level_reg <= level_next;
            fin_reg   <= fin_next;
            pend_reg  <= pend_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_mode;
            addr_reg  <= s_instr_addr;
            barg_reg  <= s_byte_arg;
            inc_reg   <= s_inc_arg;
            off_reg   <= s_short_arg;
            pool_reg  <= s_pool_word;
            nargs_reg <= s_method_args;
            inb_reg   <= s_in_byte;
        end
        if (state_reg == S_EXEC) begin
            swap_reg <= stk_rd_b;
        end
        rd_cnt_reg <= rd_cnt_next;
        wr_cnt_reg <= wr_cnt_next;
        res_pc_reg <= res_pc_next;
        res_ov_reg <= res_ov_next;
        res_ob_reg <= res_ob_next;
        res_st_reg <= res_st_next;
        if (state_reg == S_DONE && out_free) begin
            m_pc_reg <= res_pc_reg;
            m_ov_reg <= res_ov_reg;
            m_ob_reg <= res_ob_reg;
            m_st_reg <= res_st_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_next_pc   = m_pc_reg;
    assign m_out_valid = m_ov_reg;
    assign m_out_byte  = m_ob_reg;
    assign m_status    = m_st_reg;

    // checks
    a_top_above_base: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg >= base_reg)
        else $error("stack top below frame base");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(level_reg) <= FRAME_DEPTH - 1)
        else $error("frame level out of range");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY || state_reg == S_EXEC || state_reg == S_SWAP) |-> !s_ready)
        else $error("transaction accepted while executing");

    a_copy_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY) |-> (wr_cnt_reg <= rd_cnt_reg &&
                                    rd_cnt_reg <= CNTW'(nargs_reg)))
        else $error("argument copy counters out of order");

    a_error_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && res_st_next != ST_RUN) |=> fin_reg)
        else $error("halt or error did not set finished flag");

endmodule
